// ===== rtl/scht_pkg.sv =====
`timescale 1ns / 1ps
package scht_pkg;

   localparam int DIV_W = 33;

   localparam logic [2:0] KIND_TICK      = 3'd0;
   localparam logic [2:0] KIND_START_REL = 3'd1;
   localparam logic [2:0] KIND_START_ABS = 3'd2;
   localparam logic [2:0] KIND_STOP      = 3'd3;
   localparam logic [2:0] KIND_SYNC      = 3'd4;
   localparam logic [2:0] KIND_WRITE     = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_TABLE = 2'd1;
   localparam logic [1:0] ST_WRONG     = 2'd2;
   localparam logic [1:0] ST_RANGE     = 2'd3;

   localparam logic [1:0] TS_STOP = 2'd0;
   localparam logic [1:0] TS_WAIT = 2'd1;
   localparam logic [1:0] TS_RUN  = 2'd2;

   localparam logic [1:0] ACT_TASK  = 2'd0;
   localparam logic [1:0] ACT_EVENT = 2'd1;
   localparam logic [1:0] ACT_CB    = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   localparam logic [1:0] REG_COUNTER_MAX = 2'd0;
   localparam logic [1:0] REG_DURATION    = 2'd1;
   localparam logic [1:0] REG_REPEAT      = 2'd2;
   localparam logic [1:0] REG_POINT_COUNT = 2'd3;

   localparam logic [31:0] DEFAULT_DURATION = 32'd5000;

   typedef struct packed {
      logic [31:0] offset;
      logic [1:0]  act;
      logic [7:0]  task_id;
      logic [31:0] ev_mask;
      logic [7:0]  cb_id;
   } point_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        action_valid;
      logic [1:0]  action_kind;
      logic [7:0]  action_task;
      logic [31:0] action_event;
      logic [7:0]  action_callback;
      logic        last;
   } rsp_type;

endpackage

// ===== rtl/scht_if.sv =====
`timescale 1ns / 1ps
interface scht_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  table_num;
   logic [31:0] counter_value;
   logic [31:0] time_value;
   logic [3:0]  point_index;
   logic [31:0] point_offset;
   logic [1:0]  point_action;
   logic [7:0]  point_task;
   logic [31:0] point_event;
   logic [7:0]  point_callback;

   modport source (output valid, kind, table_num, counter_value, time_value, point_index,
                   point_offset, point_action, point_task, point_event, point_callback,
                   input ready);
   modport sink (input valid, kind, table_num, counter_value, time_value, point_index,
                 point_offset, point_action, point_task, point_event, point_callback,
                 output ready);
endinterface

interface scht_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        action_valid;
   logic [1:0]  action_kind;
   logic [7:0]  action_task;
   logic [31:0] action_event;
   logic [7:0]  action_callback;
   logic        last;

   modport source (output valid, status, action_valid, action_kind, action_task,
                   action_event, action_callback, last, input ready);
   modport sink (input valid, status, action_valid, action_kind, action_task,
                 action_event, action_callback, last, output ready);
endinterface

// ===== rtl/schedule_table_sequencer.sv =====
`timescale 1ns / 1ps
// Schedule table sequencer: one table of expiry points driven by one counter.
// req_chan (valid/ready) carries one command beat: tick, start relative, start
// absolute, stop, sync or write point. rsp_chan (valid/ready) returns one or
// more beats per command: each expired point as an action beat, or a single
// status beat; the final beat of a command has last set.
// csr_we/csr_index/csr_wdata write counter_max, table_duration, repeat_mode
// and point_count; write them only while no command is in flight.
// Command steps: write, stop, sync errors and a tick on a stopped table are
// accepted and then load the status beat; a tick on a started table also
// reads points; a start or sync first runs the modulo on the bit-serial
// remainder unit (one bit per cycle), and a start then scans the points in
// use for offset zero; a tick that ends a period adds the two remainder
// passes of the realignment. Points are read from a synchronous memory, one
// per visit.
// Reset clears the table state to stopped and the registers to their
// defaults; point slots hold garbage until written.
// A stalled receiver holds the output beat; the sequencer waits with it and
// takes no new command until its last beat is handed to the output register.
module schedule_table_sequencer #(
   parameter int MAX_POINTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   scht_req_if.sink    req_chan,
   scht_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import scht_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DIVEL, S_DIVST, S_DIVSTART, S_RE2, S_RD, S_CHK, S_FIN
   } fsm_type;

   fsm_type state_ff, state_in;

   logic [31:0] cmax_ff, dur_ff;
   logic        rep_ff;
   logic [4:0]  pcnt_ff;

   logic [1:0]  tstate_ff, tstate_in;
   logic [31:0] start_ff, start_in;
   logic [CW-1:0] np_ff, np_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [2:0]  kind_ff, kind_in;
   logic [31:0] cv_ff, cv_in;
   logic [31:0] el_ff, el_in;
   logic        tickrun_ff, tickrun_in;
   logic        zero_ff, zero_in;
   logic [1:0]  status_ff, status_in;

   logic             div_go_ff, div_go_in;
   logic [DIV_W-1:0] div_a_ff, div_a_in, div_b_ff, div_b_in;
   logic             div_busy, div_done;
   logic [DIV_W-1:0] div_rem;

   rsp_type pend_ff, pend_in;
   logic    pend_v_ff, pend_v_in;
   rsp_type out_ff, out_in;
   logic    out_v_ff, out_v_in;
   logic    out_free;

   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   point_type       mem_wdata;
   logic            mem_re;
   logic [AW-1:0]   mem_raddr;
   point_type       mem_rdata;

   logic [DIV_W-1:0] period33, mod33;
   logic [CW-1:0]    used;
   logic             too_large;
   logic [31:0]      el_now, el_re;
   logic [31:0]      skip;
   rsp_type          act_beat;
   logic             hit, emit;

   function automatic logic [31:0] elapsed(input logic [31:0] cur, input logic [31:0] st,
                                           input logic [31:0] cmax);
      elapsed = (cur >= st) ? cur - st : cmax - st + cur;
   endfunction

   scht_point_mem #(.DEPTH(MAX_POINTS), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   scht_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (div_a_ff),
      .divisor  (div_b_ff),
      .busy     (div_busy),
      .done     (div_done),
      .rem      (div_rem)
   );

   assign period33  = (dur_ff == '0) ? {1'b1, 32'd0} : {1'b0, dur_ff};
   assign mod33     = (cmax_ff == '0) ? {1'b1, 32'd0} : {1'b0, cmax_ff};
   assign used      = (32'(pcnt_ff) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(pcnt_ff);
   assign too_large = (cmax_ff != '0) && (req_chan.time_value > cmax_ff);
   assign el_now    = elapsed(req_chan.counter_value, start_ff, cmax_ff);
   assign el_re     = elapsed(cv_ff, start_ff, cmax_ff);
   assign skip      = el_ff - div_rem[31:0];
   assign out_free  = !out_v_ff || rsp_chan.ready;

   assign mem_waddr = AW'(req_chan.point_index);
   assign mem_wdata = '{offset: req_chan.point_offset, act: req_chan.point_action,
                        task_id: req_chan.point_task, ev_mask: req_chan.point_event,
                        cb_id: req_chan.point_callback};

   always_comb begin
      act_beat = '0;
      act_beat.status = ST_OK;
      act_beat.action_valid = 1'b1;
      act_beat.action_kind = mem_rdata.act;
      case (mem_rdata.act)
         ACT_TASK:  act_beat.action_task = mem_rdata.task_id;
         ACT_EVENT: begin
            act_beat.action_task  = mem_rdata.task_id;
            act_beat.action_event = mem_rdata.ev_mask;
         end
         ACT_CB:    act_beat.action_callback = mem_rdata.cb_id;
         default:   act_beat.action_valid = 1'b0;
      endcase
      hit  = zero_ff ? (mem_rdata.offset == '0) : (mem_rdata.offset <= el_ff);
      emit = hit && (mem_rdata.act != ACT_NONE);
   end

   always_comb begin
      state_in   = state_ff;
      tstate_in  = tstate_ff;
      start_in   = start_ff;
      np_in      = np_ff;
      scan_in    = scan_ff;
      kind_in    = kind_ff;
      cv_in      = cv_ff;
      el_in      = el_ff;
      tickrun_in = tickrun_ff;
      zero_in    = zero_ff;
      status_in  = status_ff;
      div_go_in  = 1'b0;
      div_a_in   = div_a_ff;
      div_b_in   = div_b_ff;
      pend_in    = pend_ff;
      pend_v_in  = pend_v_ff;
      out_in     = out_ff;
      out_v_in   = out_v_ff && !rsp_chan.ready;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_raddr  = zero_ff ? scan_ff[AW-1:0] : np_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               kind_in   = req_chan.kind;
               cv_in     = req_chan.counter_value;
               status_in = ST_OK;
               zero_in   = 1'b0;
               state_in  = S_FIN;
               if (req_chan.kind <= KIND_WRITE && req_chan.table_num != '0) begin
                  status_in = ST_BAD_TABLE;
               end else begin
                  case (req_chan.kind)
                     KIND_TICK: begin
                        el_in = el_now;
                        if (tstate_ff == TS_WAIT) begin
                           np_in = '0;
                           tickrun_in = 1'b0;
                           if ({1'b0, el_now} < period33) begin
                              tstate_in = TS_RUN;
                              state_in  = S_RD;
                           end else if (rep_ff) begin
                              div_go_in = 1'b1;
                              div_a_in  = {1'b0, el_now};
                              div_b_in  = period33;
                              state_in  = S_DIVEL;
                           end else begin
                              tstate_in = TS_STOP;
                           end
                        end else if (tstate_ff == TS_RUN) begin
                           tickrun_in = 1'b1;
                           state_in   = S_RD;
                        end
                     end
                     KIND_START_REL, KIND_START_ABS: begin
                        if (tstate_ff != TS_STOP) begin
                           status_in = ST_WRONG;
                        end else if (too_large) begin
                           status_in = ST_RANGE;
                        end else begin
                           div_go_in = 1'b1;
                           div_a_in  = (req_chan.kind == KIND_START_REL) ?
                                       {1'b0, req_chan.counter_value} + {1'b0, req_chan.time_value} :
                                       {1'b0, req_chan.time_value};
                           div_b_in  = mod33;
                           state_in  = S_DIVSTART;
                        end
                     end
                     KIND_STOP: begin
                        if (tstate_ff == TS_STOP) begin
                           status_in = ST_WRONG;
                        end else begin
                           tstate_in = TS_STOP;
                           np_in     = '0;
                        end
                     end
                     KIND_SYNC: begin
                        if (tstate_ff == TS_STOP) begin
                           status_in = ST_WRONG;
                        end else if (too_large) begin
                           status_in = ST_RANGE;
                        end else begin
                           div_go_in = 1'b1;
                           div_a_in  = {1'b0, req_chan.counter_value} + {1'b0, req_chan.time_value};
                           div_b_in  = mod33;
                           state_in  = S_DIVSTART;
                        end
                     end
                     KIND_WRITE: begin
                        if (32'(req_chan.point_index) >= 32'(MAX_POINTS)) begin
                           status_in = ST_RANGE;
                        end else begin
                           mem_we = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         S_DIVEL: begin
            if (div_done) begin
               div_go_in = 1'b1;
               div_a_in  = {1'b0, start_ff} + {1'b0, skip};
               div_b_in  = mod33;
               state_in  = S_DIVST;
            end
         end
         S_DIVST: begin
            if (div_done) begin
               start_in = div_rem[31:0];
               np_in    = '0;
               if (tickrun_ff) begin
                  tstate_in = TS_WAIT;
                  state_in  = S_RE2;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_DIVSTART: begin
            if (div_done) begin
               start_in  = div_rem[31:0];
               tstate_in = TS_WAIT;
               np_in     = '0;
               if (kind_ff == KIND_SYNC) begin
                  state_in = S_FIN;
               end else begin
                  zero_in  = 1'b1;
                  scan_in  = '0;
                  state_in = S_RD;
               end
            end
         end
         S_RE2: begin
            tickrun_in = 1'b0;
            if ({1'b0, el_re} < period33) begin
               tstate_in = TS_RUN;
               el_in     = el_re;
               state_in  = S_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_RD: begin
            if (zero_ff ? (scan_ff < used) : (np_ff < used)) begin
               mem_re   = 1'b1;
               state_in = S_CHK;
            end else begin
               state_in = S_FIN;
            end
         end
         S_CHK: begin
            if (!hit) begin
               if (zero_ff) begin
                  scan_in  = scan_ff + 1'b1;
                  state_in = S_RD;
               end else begin
                  state_in = S_FIN;
               end
            end else if (!(emit && pend_v_ff && !out_free)) begin
               if (emit) begin
                  if (pend_v_ff) begin
                     out_in   = pend_ff;
                     out_v_in = 1'b1;
                  end
                  pend_in   = act_beat;
                  pend_v_in = 1'b1;
               end
               if (zero_ff) begin
                  scan_in = scan_ff + 1'b1;
               end else begin
                  np_in = np_ff + 1'b1;
               end
               state_in = S_RD;
            end
         end
         S_FIN: begin
            if (!zero_ff && tickrun_ff && ({1'b0, el_ff} >= period33)) begin
               if (rep_ff) begin
                  div_go_in = 1'b1;
                  div_a_in  = {1'b0, el_ff};
                  div_b_in  = period33;
                  state_in  = S_DIVEL;
               end else begin
                  tstate_in  = TS_STOP;
                  np_in      = '0;
                  tickrun_in = 1'b0;
               end
            end else if (out_free) begin
               out_v_in = 1'b1;
               if (pend_v_ff) begin
                  out_in      = pend_ff;
                  out_in.last = 1'b1;
               end else begin
                  out_in        = '0;
                  out_in.status = status_ff;
                  out_in.last   = 1'b1;
               end
               pend_v_in  = 1'b0;
               tickrun_in = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         tstate_ff  <= TS_STOP;
         start_ff   <= '0;
         np_ff      <= '0;
         tickrun_ff <= 1'b0;
         zero_ff    <= 1'b0;
         div_go_ff  <= 1'b0;
         pend_v_ff  <= 1'b0;
         out_v_ff   <= 1'b0;
         cmax_ff    <= '1;
         dur_ff     <= DEFAULT_DURATION;
         rep_ff     <= 1'b1;
         pcnt_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         tstate_ff  <= tstate_in;
         start_ff   <= start_in;
         np_ff      <= np_in;
         tickrun_ff <= tickrun_in;
         zero_ff    <= zero_in;
         div_go_ff  <= div_go_in;
         pend_v_ff  <= pend_v_in;
         out_v_ff   <= out_v_in;
         if (csr_we) begin
            case (csr_index)
               REG_COUNTER_MAX: cmax_ff <= csr_wdata;
               REG_DURATION:    dur_ff  <= csr_wdata;
               REG_REPEAT:      rep_ff  <= csr_wdata[0];
               REG_POINT_COUNT: pcnt_ff <= csr_wdata[4:0];
               default: ;
            endcase
         end
      end
      scan_ff   <= scan_in;
      kind_ff   <= kind_in;
      cv_ff     <= cv_in;
      el_ff     <= el_in;
      status_ff <= status_in;
      div_a_ff  <= div_a_in;
      div_b_ff  <= div_b_in;
      pend_ff   <= pend_in;
      out_ff    <= out_in;
   end

   assign req_chan.ready           = (state_ff == S_IDLE);
   assign rsp_chan.valid           = out_v_ff;
   assign rsp_chan.status          = out_ff.status;
   assign rsp_chan.action_valid    = out_ff.action_valid;
   assign rsp_chan.action_kind     = out_ff.action_kind;
   assign rsp_chan.action_task     = out_ff.action_task;
   assign rsp_chan.action_event    = out_ff.action_event;
   assign rsp_chan.action_callback = out_ff.action_callback;
   assign rsp_chan.last            = out_ff.last;

   a_idle_no_div: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !div_busy && !div_go_ff)
      else $error("command taken while remainder unit busy");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_v_ff)
      else $error("held action beat left behind at command end");

   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("second command taken before first finished");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIVEL || state_ff == S_DIVST || state_ff == S_DIVSTART)
      else $error("remainder result arrived with nobody waiting");
endmodule

// ===== rtl/scht_point_mem.sv =====
`timescale 1ns / 1ps
module scht_point_mem #(
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  scht_pkg::point_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output scht_pkg::point_type rd_data
);
   import scht_pkg::*;

   point_type mem [DEPTH];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/scht_rem_unit.sv =====
`timescale 1ns / 1ps
module scht_rem_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [scht_pkg::DIV_W-1:0]  dividend,
   input  logic [scht_pkg::DIV_W-1:0]  divisor,
   output logic                        busy,
   output logic                        done,
   output logic [scht_pkg::DIV_W-1:0]  rem
);
   import scht_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] a_ff;
   logic [DIV_W-1:0] b_ff;
   logic [DIV_W-1:0] r_ff;
   logic [DIV_W-1:0] r_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DIV_W:0]   trial;

   always_comb begin
      trial = {r_ff, a_ff[DIV_W-1]};
      if (trial >= {1'b0, b_ff}) begin
         r_in = DIV_W'(trial - {1'b0, b_ff});
      end else begin
         r_in = trial[DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            a_ff    <= dividend;
            b_ff    <= divisor;
            r_ff    <= '0;
            cnt_ff  <= CNT_W'(DIV_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            r_ff   <= r_in;
            a_ff   <= {a_ff[DIV_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign rem  = r_ff;
endmodule
